// File: rtl/assert_macros.svh
// Assertion macros for the RTL files that check themselves
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge of clk outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/kfd_pkg.sv
// Types and constants of the KISS frame decoder
package kfd_pkg;

  localparam logic [7:0] FEND        = 8'hC0;
  localparam logic [7:0] FESC        = 8'hDB;
  localparam logic [7:0] TFEND       = 8'hDC;
  localparam logic [7:0] TFESC       = 8'hDD;
  localparam logic [3:0] CMD_PAYLOAD = 4'h0;

  localparam int unsigned LEN_W = 10;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 10'd330;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic             inside_frame;
    logic             escape_pending;
    logic             command_known;
    logic [3:0]       command_code;
    logic [3:0]       port_held;
    logic [LEN_W-1:0] byte_count;
  } dec_state_t;

  typedef struct packed {
    item_kind_t       item_kind;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] frame_length;
    logic [3:0]       port_number;
  } dec_result_t;

endpackage

// File: rtl/kfd_step.sv
// Next-state and result logic of the decoder for one raw byte
module kfd_step (
  input  kfd_pkg::dec_state_t        state_i,
  input  logic [7:0]                 rx_byte_i,
  input  logic [kfd_pkg::LEN_W-1:0]  max_len_i,
  output kfd_pkg::dec_state_t        state_o,
  output logic                       res_valid_o,
  output kfd_pkg::dec_result_t       res_o
);

  logic data_frame;

  assign data_frame = state_i.command_known &&
                      (state_i.command_code == kfd_pkg::CMD_PAYLOAD);

  always_comb begin
    state_o            = state_i;
    res_valid_o        = 1'b0;
    res_o.item_kind    = kfd_pkg::KIND_DATA;
    res_o.data_byte    = 8'h00;
    res_o.frame_length = '0;
    res_o.port_number  = state_i.port_held;
    if (state_i.inside_frame && rx_byte_i == kfd_pkg::FEND && data_frame) begin
      state_o.inside_frame = 1'b0;
      res_valid_o          = 1'b1;
      res_o.item_kind      = kfd_pkg::KIND_END;
      res_o.frame_length   = state_i.byte_count;
    end else if (rx_byte_i == kfd_pkg::FEND) begin
      state_o.inside_frame  = 1'b1;
      state_o.command_known = 1'b0;
      state_o.byte_count    = '0;
    end else if (!state_i.inside_frame || state_i.byte_count >= max_len_i) begin
      state_o = state_i;
    end else if (state_i.byte_count == '0 && !state_i.command_known) begin
      state_o.port_held     = rx_byte_i[7:4];
      state_o.command_code  = rx_byte_i[3:0];
      state_o.command_known = 1'b1;
    end else if (!data_frame) begin
      state_o = state_i;
    end else if (rx_byte_i == kfd_pkg::FESC) begin
      state_o.escape_pending = 1'b1;
    end else begin
      res_valid_o     = 1'b1;
      res_o.data_byte = rx_byte_i;
      if (state_i.escape_pending) begin
        if (rx_byte_i == kfd_pkg::TFEND) begin
          res_o.data_byte = kfd_pkg::FEND;
        end else if (rx_byte_i == kfd_pkg::TFESC) begin
          res_o.data_byte = kfd_pkg::FESC;
        end
      end
      state_o.escape_pending = 1'b0;
      state_o.byte_count     = state_i.byte_count + 1'b1;
    end
  end

endmodule

// File: rtl/kiss_frame_decoder.sv
// KISS frame decoder top level: input register, decode step, result register
// One byte is accepted per cycle while out_tready does not stall, a throughput set by
// the single decode step between the input register and the result register, which
// also holds results while out_tready is low; results go from the input register
// through the decode step into it. Data bytes of command-0 frames come out unescaped
// (out_tuser low), a closing FEND of such a frame gives an end marker (out_tuser high)
// with the frame length; bytes beyond the length limit in cfg_data are dropped.
// The limit may only be changed while the decoder is idle.
`include "assert_macros.svh"

module kiss_frame_decoder (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] rx_byte
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [23:0]               out_tdata,  // [7:0] data_byte, [17:8] frame_length,
                                                // [21:18] port_number, [23:22] zero
  output logic                      out_tuser,  // [0] item_kind
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [kfd_pkg::LEN_W-1:0] cfg_data   // max_frame_length
);

  logic [kfd_pkg::LEN_W-1:0] max_len_r;
  logic                      s1_valid_r;
  logic [7:0]                s1_byte_r;
  kfd_pkg::dec_state_t       state_r;
  kfd_pkg::dec_state_t       state_nxt;
  logic                      out_valid_r;
  kfd_pkg::dec_result_t      out_res_r;
  logic                      res_valid;
  kfd_pkg::dec_result_t      res;
  logic                      out_free;
  logic                      fire;
  logic                      data_fire;
  logic                      end_fire;
  logic [kfd_pkg::LEN_W-1:0] count_inc;

  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign fire       = s1_valid_r && out_free;
  assign in_tready  = !s1_valid_r || fire;

  kfd_step u_step (
    .state_i     (state_r),
    .rx_byte_i   (s1_byte_r),
    .max_len_i   (max_len_r),
    .state_o     (state_nxt),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= kfd_pkg::MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.item_kind;
  assign out_tdata  = {2'b00, out_res_r.port_number, out_res_r.frame_length,
                       out_res_r.data_byte};

  assign data_fire = fire && res_valid && (res.item_kind == kfd_pkg::KIND_DATA);
  assign end_fire  = fire && res_valid && (res.item_kind == kfd_pkg::KIND_END);
  assign count_inc = state_r.byte_count + 1'b1;

  `ASSERT_CLK(a_data_counts, data_fire |=> state_r.byte_count == $past(count_inc), "count stuck")
  `ASSERT_CLK(a_end_leaves, end_fire |=> !state_r.inside_frame, "end marker left frame open")
  `ASSERT_NEVER(a_over_limit, data_fire && state_r.byte_count >= max_len_r, "item past limit")

endmodule
